>>> rtl/core/hspl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hspl_pkg
// Shared sizes, codes and controller/datapath interface types for the
// hash slot probe lookup block.
// ----------------------------------------------------------------------------
package hspl_pkg;

	localparam int MAX_SLOTS = 256;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CAP_W     = 9;
	localparam int KEY_W     = 32;
	localparam int WIDE_W    = 64;

	// dividend bits retired per cycle by the home slot divider
	localparam int MOD_BITS  = 4;
	localparam int MOD_STEPS = WIDE_W / MOD_BITS;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	// probe offsets stay below capacity plus one step, steps stay small
	localparam int OFF_W     = SLOT_W + 2;
	localparam int STEP_W    = SLOT_W + 1;

	localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
	localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(MAX_SLOTS);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;
	localparam logic [CAP_W-1:0]   CAPACITY_RST = CAP_W'(6);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SEEK  = 1'b1;

	localparam logic [1:0] ST_WRITTEN = 2'd0;
	localparam logic [1:0] ST_FOUND   = 2'd1;
	localparam logic [1:0] ST_FREE    = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic       load_item;
		logic       mod_step;
		logic       inner_init;
		logic       outer_adv;
		logic       probe_read;
		logic       inner_adv;
		logic       set_res;
		logic [1:0] res_status;
		logic       res_home;
		logic       load_out;
	} hspl_cmd_t;

	typedef struct packed {
		logic outer_lt_cap;
		logic off_lt_cap;
		logic occ_hit;
		logic key_hit;
	} hspl_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/hash_slot_probe_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hash_slot_probe_lookup
// Open-addressed slot table with triangular probe seek.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. A write stores the slot at the accept
// edge and loads its result into the output register once that register is
// free. A seek first computes the home slot remainder (4 key bits per cycle
// over the 64-bit sign-extended key), then walks the probe sequence: each
// probed slot takes an address step, then a registered memory read and
// compare; each outer probe pass and each closed inner run adds a step of
// its own, and a last step loads the output register once it is free. A
// crowded table takes longer. The next request is taken in the cycle after
// the result is loaded into the output register, even while that result
// still waits under stall. Occupied marks clear at reset; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module hash_slot_probe_lookup (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [hspl_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [hspl_pkg::PDATA_W-1:0]       pwdata,
	output logic      [hspl_pkg::PDATA_W-1:0]       prdata,
	output logic                                    pready,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire logic                               command,
	input  wire logic signed [hspl_pkg::KEY_W-1:0]  key,
	input  wire logic [hspl_pkg::SLOT_W-1:0]        slot,
	input  wire logic                               occupied,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	output logic      [hspl_pkg::SLOT_W-1:0]        slot_index,
	output logic      [1:0]                         status
);

	logic [hspl_pkg::CAP_W-1:0] capacity;
	hspl_pkg::hspl_cmd_t        cmd;
	hspl_pkg::hspl_sts_t        sts;

	hspl_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	hspl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.command   (command),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	hspl_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.capacity   (capacity),
		.command    (command),
		.key        (key),
		.slot       (slot),
		.occupied   (occupied),
		.cmd        (cmd),
		.sts        (sts),
		.slot_index (slot_index),
		.status     (status)
	);

endmodule

`default_nettype wire

>>> rtl/core/hspl_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hspl_regs
// APB-style register port holding the capacity register.
// ----------------------------------------------------------------------------
module hspl_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [hspl_pkg::PADDR_W-1:0] paddr,
	input  wire logic [hspl_pkg::PDATA_W-1:0] pwdata,
	output logic      [hspl_pkg::PDATA_W-1:0] prdata,
	output logic                              pready,
	output logic      [hspl_pkg::CAP_W-1:0]   capacity
);

	logic [hspl_pkg::CAP_W-1:0]     capacity_q;
	logic [hspl_pkg::PADDR_W-3:0]   reg_idx;
	logic                           wr_en;

	assign reg_idx = paddr[hspl_pkg::PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= hspl_pkg::CAPACITY_RST;
		end else if (wr_en && (reg_idx == hspl_pkg::REG_CAPACITY)) begin
			capacity_q <= pwdata[hspl_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			hspl_pkg::REG_CAPACITY: prdata = hspl_pkg::PDATA_W'(capacity_q);
			default:                prdata = '0;
		endcase
	end

	assign capacity = capacity_q;

endmodule

`default_nettype wire

>>> rtl/core/hspl_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hspl_dpath
// Slot memory, occupied marks, home slot divider, probe offset walk and
// result registers.
// ----------------------------------------------------------------------------
module hspl_dpath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [hspl_pkg::CAP_W-1:0]         capacity,
	input  wire logic                               command,
	input  wire logic signed [hspl_pkg::KEY_W-1:0]  key,
	input  wire logic [hspl_pkg::SLOT_W-1:0]        slot,
	input  wire logic                               occupied,
	input  wire hspl_pkg::hspl_cmd_t                cmd,
	output hspl_pkg::hspl_sts_t                     sts,
	output logic [hspl_pkg::SLOT_W-1:0]             slot_index,
	output logic [1:0]                              status
);

	logic [hspl_pkg::KEY_W-1:0]   slot_keys [hspl_pkg::MAX_SLOTS];
	logic [hspl_pkg::MAX_SLOTS-1:0] occ_q;

	logic [hspl_pkg::CAP_W-1:0]   cap_eff;
	logic [hspl_pkg::WIDE_W-1:0]  div_q;
	logic [hspl_pkg::KEY_W-1:0]   key_q;
	logic [hspl_pkg::SLOT_W-1:0]  rem_q;
	logic [hspl_pkg::SLOT_W-1:0]  rem_nxt;
	logic [hspl_pkg::SLOT_W:0]    trial;

	logic [hspl_pkg::OFF_W-1:0]   outer_off_q;
	logic [hspl_pkg::STEP_W-1:0]  outer_step_q;
	logic [hspl_pkg::STEP_W-1:0]  outer_step_nxt;
	logic [hspl_pkg::OFF_W-1:0]   off_q;
	logic [hspl_pkg::STEP_W-1:0]  step_q;
	logic [hspl_pkg::OFF_W-1:0]   cap_wide;
	logic [hspl_pkg::OFF_W-1:0]   cand_sum;
	logic [hspl_pkg::SLOT_W-1:0]  cand;

	logic [hspl_pkg::SLOT_W-1:0]  cand_q;
	logic [hspl_pkg::KEY_W-1:0]   key_rd_q;
	logic                         occ_rd_q;

	logic [hspl_pkg::SLOT_W-1:0]  res_slot_q;
	logic [1:0]                   res_status_q;
	logic [hspl_pkg::SLOT_W-1:0]  slot_index_q;
	logic [1:0]                   status_q;

	logic                         wr_item;

	// clamp the capacity register into the legal range
	always_comb begin
		if (capacity < hspl_pkg::CAP_MIN) begin
			cap_eff = hspl_pkg::CAP_MIN;
		end else if (capacity > hspl_pkg::CAP_MAX) begin
			cap_eff = hspl_pkg::CAP_MAX;
		end else begin
			cap_eff = capacity;
		end
	end

	assign cap_wide = hspl_pkg::OFF_W'(cap_eff);

	// restoring remainder, a few dividend bits per cycle
	always_comb begin
		rem_nxt = rem_q;
		trial   = '0;
		for (int i = 0; i < hspl_pkg::MOD_BITS; i++) begin
			trial = {rem_nxt, div_q[hspl_pkg::WIDE_W-1-i]};
			if (trial >= cap_eff) begin
				trial = trial - cap_eff;
			end
			rem_nxt = trial[hspl_pkg::SLOT_W-1:0];
		end
	end

	// home plus offset, both below capacity
	always_comb begin
		cand_sum = hspl_pkg::OFF_W'(rem_q) + off_q;
		if (cand_sum >= cap_wide) begin
			cand_sum = cand_sum - cap_wide;
		end
		cand = cand_sum[hspl_pkg::SLOT_W-1:0];
	end

	assign outer_step_nxt = outer_step_q + 1'b1;
	assign wr_item        = cmd.load_item && (command == hspl_pkg::CMD_WRITE);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			div_q        <= {{(hspl_pkg::WIDE_W-hspl_pkg::KEY_W){key[hspl_pkg::KEY_W-1]}}, key};
			key_q        <= key;
			rem_q        <= '0;
			outer_off_q  <= '0;
			outer_step_q <= '0;
		end else if (cmd.mod_step) begin
			div_q <= div_q << hspl_pkg::MOD_BITS;
			rem_q <= rem_nxt;
		end else if (cmd.outer_adv) begin
			outer_step_q <= outer_step_nxt;
			outer_off_q  <= outer_off_q + hspl_pkg::OFF_W'(outer_step_nxt);
		end
		if (cmd.inner_init) begin
			off_q  <= outer_off_q + hspl_pkg::OFF_W'(outer_step_q);
			step_q <= outer_step_nxt;
		end else if (cmd.inner_adv) begin
			off_q  <= off_q + hspl_pkg::OFF_W'(step_q);
			step_q <= step_q + 1'b1;
		end
	end

	// key store, no reset
	always_ff @(posedge clk) begin
		if (wr_item) begin
			slot_keys[slot] <= key;
		end
		if (cmd.probe_read) begin
			key_rd_q <= slot_keys[cand];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (wr_item) begin
			occ_q[slot] <= occupied;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe_read) begin
			occ_rd_q <= occ_q[cand];
			cand_q   <= cand;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_item) begin
			res_slot_q   <= slot;
			res_status_q <= hspl_pkg::ST_WRITTEN;
		end else if (cmd.set_res) begin
			res_slot_q   <= cmd.res_home ? rem_q : cand_q;
			res_status_q <= cmd.res_status;
		end
		if (cmd.load_out) begin
			slot_index_q <= res_slot_q;
			status_q     <= res_status_q;
		end
	end

	assign sts.outer_lt_cap = (outer_off_q < cap_wide);
	assign sts.off_lt_cap   = (off_q < cap_wide);
	assign sts.occ_hit      = occ_rd_q;
	assign sts.key_hit      = (key_rd_q == key_q);

	assign slot_index = slot_index_q;
	assign status     = status_q;

endmodule

`default_nettype wire

>>> rtl/core/hspl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hspl_ctrl
// Sequencer for write, home slot division, probe walk and result handoff.
// ----------------------------------------------------------------------------
module hspl_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire logic                 command,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	input  wire hspl_pkg::hspl_sts_t  sts,
	output hspl_pkg::hspl_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MOD   = 3'd1;
	localparam logic [2:0] S_OUTER = 3'd2;
	localparam logic [2:0] S_INNER = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]                       state_q;
	logic [2:0]                       state_nxt;
	logic [hspl_pkg::MOD_CNT_W-1:0]   mod_cnt_q;
	logic                             rsp_valid_q;
	logic                             out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_nxt = (command == hspl_pkg::CMD_WRITE) ? S_DONE : S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (mod_cnt_q == hspl_pkg::MOD_CNT_W'(hspl_pkg::MOD_STEPS - 1)) begin
					state_nxt = S_OUTER;
				end
			end
			S_OUTER: begin
				if (sts.outer_lt_cap) begin
					cmd.inner_init = 1'b1;
					state_nxt = S_INNER;
				end else begin
					cmd.set_res    = 1'b1;
					cmd.res_status = hspl_pkg::ST_FULL;
					cmd.res_home   = 1'b1;
					state_nxt = S_DONE;
				end
			end
			S_INNER: begin
				if (sts.off_lt_cap) begin
					cmd.probe_read = 1'b1;
					state_nxt = S_CHECK;
				end else begin
					cmd.outer_adv = 1'b1;
					state_nxt = S_OUTER;
				end
			end
			S_CHECK: begin
				if (!sts.occ_hit) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = hspl_pkg::ST_FREE;
					state_nxt = S_DONE;
				end else if (sts.key_hit) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = hspl_pkg::ST_FOUND;
					state_nxt = S_DONE;
				end else begin
					cmd.inner_adv = 1'b1;
					state_nxt = S_INNER;
				end
			end
			S_DONE: begin
				// hand the result over once the output register is free
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mod_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_item) begin
				mod_cnt_q <= '0;
			end else if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire
